@@ design/ipv4rx_pkg.sv @@
// ----------------------------------------------------------------------------
// ipv4rx_pkg: shared types and constants for the IPv4 receive header check
// Verdict codes, header constants and the packet summary passed from the
// parser to the verdict stage.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4rx_pkg;

	localparam int MIN_HEADER_BYTES = 20;
	localparam int UDP_HEADER_BYTES = 8;

	localparam logic [3:0]  IP_VERSION = 4'd4;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [15:0] COUNT_MAX  = 16'hffff;

	// byte offsets inside the IPv4 header
	localparam logic [15:0] POS_VER_IHL   = 16'd0;
	localparam logic [15:0] POS_LEN_HI    = 16'd2;
	localparam logic [15:0] POS_LEN_LO    = 16'd3;
	localparam logic [15:0] POS_PROTOCOL  = 16'd9;
	localparam logic [15:0] POS_CSUM_HI   = 16'd10;
	localparam logic [15:0] POS_CSUM_LO   = 16'd11;
	localparam logic [15:0] POS_SRC_FIRST = 16'd12;
	localparam logic [15:0] POS_SRC_LAST  = 16'd15;
	localparam logic [15:0] POS_DST_FIRST = 16'd16;
	localparam logic [15:0] POS_DST_LAST  = 16'd19;

	typedef enum logic [2:0] {
		VERDICT_UDP          = 3'd0,
		VERDICT_ICMP         = 3'd1,
		VERDICT_PROTO_UNREACH = 3'd2,
		VERDICT_UDP_SHORT    = 3'd3,
		VERDICT_BAD_VERSION  = 3'd4,
		VERDICT_BAD_LENGTH   = 3'd5,
		VERDICT_BAD_CHECKSUM = 3'd6,
		VERDICT_NOT_OURS     = 3'd7
	} verdict_t;

	// header state as it stands after the last byte of a packet
	typedef struct packed {
		logic        done;
		logic [3:0]  version;
		logic [3:0]  ihl;
		logic [15:0] length;
		logic [7:0]  protocol;
		logic [15:0] checksum;
		logic [15:0] sum;
		logic [31:0] source;
		logic        dest_match;
		logic [15:0] port;
		logic [15:0] count;
	} pkt_t;

endpackage

`default_nettype wire

@@ design/ipv4rx_if.sv @@
// ----------------------------------------------------------------------------
// ipv4rx_if: valid/ready channels of the IPv4 receive header check
// Byte input channel, result channel and the local address write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4rx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_packet;

	modport source (output valid, data_byte, end_of_packet, input ready);
	modport sink   (input valid, data_byte, end_of_packet, output ready);
endinterface

interface ipv4rx_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [7:0]  protocol_number;
	logic [31:0] source_address;
	logic [15:0] udp_destination_port;
	logic [5:0]  header_bytes;
	logic [15:0] total_length;

	modport source (output valid, verdict, protocol_number, source_address,
		udp_destination_port, header_bytes, total_length, input ready);
	modport sink   (input valid, verdict, protocol_number, source_address,
		udp_destination_port, header_bytes, total_length, output ready);
endinterface

interface ipv4rx_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ design/ipv4rx_parse.sv @@
// ----------------------------------------------------------------------------
// ipv4rx_parse: input register and header field capture
// Registers each byte, then updates the header fields, destination match
// and ones-complement header sum; hands the final state on at end of packet.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4rx_parse (
	input  wire logic               clk,
	input  wire logic               arst_n,
	ipv4rx_byte_if.sink             rx,
	input  wire logic [31:0]        local_address,
	input  wire logic               res_free,
	output ipv4rx_pkg::pkt_t        pkt
);
	import ipv4rx_pkg::*;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eop_s1;

	// per-packet state
	logic [15:0] count_q;
	logic [7:0]  vib_q;
	logic [15:0] len_q;
	logic [7:0]  proto_q;
	logic [15:0] csum_q;
	logic [15:0] sum_q;
	logic [7:0]  held_q;
	logic [31:0] src_q;
	logic        dm_q;
	logic [15:0] port_q;

	logic [15:0] count_n, len_n, csum_n, sum_n, port_n;
	logic [7:0]  vib_n, proto_n, held_n, want;
	logic [31:0] src_n;
	logic        dm_n, active, adv;
	logic [5:0]  hb;
	logic [15:0] hb16, word;
	logic [1:0]  lane;

	assign adv      = valid_s1 && (!eop_s1 || res_free);
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data_byte;
			eop_s1  <= rx.end_of_packet;
		end
	end

	always_comb begin
		active  = count_q != COUNT_MAX;
		vib_n   = (active && count_q == POS_VER_IHL) ? byte_s1 : vib_q;
		hb      = {vib_n[3:0], 2'b00};
		hb16    = {10'd0, hb};
		lane    = 2'd3 - count_q[1:0];
		want    = local_address[{lane, 3'b000} +: 8];
		word    = (count_q == POS_CSUM_LO) ? 16'd0 : {held_q, byte_s1};
		count_n = count_q;
		len_n   = len_q;
		proto_n = proto_q;
		csum_n  = csum_q;
		sum_n   = sum_q;
		held_n  = held_q;
		src_n   = src_q;
		dm_n    = dm_q;
		port_n  = port_q;
		if (active) begin
			if (count_q == POS_LEN_HI || count_q == POS_LEN_LO)
				len_n = {len_q[7:0], byte_s1};
			if (count_q == POS_PROTOCOL)
				proto_n = byte_s1;
			if (count_q == POS_CSUM_HI || count_q == POS_CSUM_LO)
				csum_n = {csum_q[7:0], byte_s1};
			if (count_q >= POS_SRC_FIRST && count_q <= POS_SRC_LAST)
				src_n = {src_q[23:0], byte_s1};
			if (count_q >= POS_DST_FIRST && count_q <= POS_DST_LAST && want != byte_s1)
				dm_n = 1'b0;
			if (count_q == hb16 + 16'd2 || count_q == hb16 + 16'd3)
				port_n = {port_q[7:0], byte_s1};
			if (count_q < hb16) begin
				if (!count_q[0])
					held_n = byte_s1;
				else
					sum_n = ones_add(sum_q, word);
			end
			count_n = count_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vib_q   <= '0;
			len_q   <= '0;
			proto_q <= '0;
			csum_q  <= '0;
			sum_q   <= '0;
			held_q  <= '0;
			src_q   <= '0;
			dm_q    <= 1'b1;
			port_q  <= '0;
		end else if (adv && eop_s1) begin
			// packet finished: start the next one clean
			count_q <= '0;
			vib_q   <= '0;
			len_q   <= '0;
			proto_q <= '0;
			csum_q  <= '0;
			sum_q   <= '0;
			held_q  <= '0;
			src_q   <= '0;
			dm_q    <= 1'b1;
			port_q  <= '0;
		end else if (adv) begin
			count_q <= count_n;
			vib_q   <= vib_n;
			len_q   <= len_n;
			proto_q <= proto_n;
			csum_q  <= csum_n;
			sum_q   <= sum_n;
			held_q  <= held_n;
			src_q   <= src_n;
			dm_q    <= dm_n;
			port_q  <= port_n;
		end
	end

	always_comb begin
		pkt.done       = adv && eop_s1;
		pkt.version    = vib_n[7:4];
		pkt.ihl        = vib_n[3:0];
		pkt.length     = len_n;
		pkt.protocol   = proto_n;
		pkt.checksum   = csum_n;
		pkt.sum        = sum_n;
		pkt.source     = src_n;
		pkt.dest_match = dm_n;
		pkt.port       = port_n;
		pkt.count      = count_n;
	end

endmodule

`default_nettype wire

@@ design/ipv4rx_verdict.sv @@
// ----------------------------------------------------------------------------
// ipv4rx_verdict: verdict decision and result register
// Applies the header checks in priority order and holds one result until
// the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4rx_verdict (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ipv4rx_pkg::pkt_t   pkt,
	output logic                    res_free,
	ipv4rx_result_if.source         res
);
	import ipv4rx_pkg::*;

	logic [5:0]  hdr;
	logic [15:0] hdr16;
	verdict_t    verdict;

	assign res_free = !res.valid || res.ready;

	always_comb begin
		hdr   = {pkt.ihl, 2'b00};
		hdr16 = {10'd0, hdr};
		if (pkt.version != IP_VERSION)
			verdict = VERDICT_BAD_VERSION;
		else if (hdr < 6'(MIN_HEADER_BYTES) || pkt.length < hdr16 || pkt.count < pkt.length)
			verdict = VERDICT_BAD_LENGTH;
		else if (pkt.checksum != ~pkt.sum)
			verdict = VERDICT_BAD_CHECKSUM;
		else if (!pkt.dest_match)
			verdict = VERDICT_NOT_OURS;
		else if (pkt.protocol == PROTO_UDP)
			verdict = (pkt.count >= hdr16 + 16'(UDP_HEADER_BYTES)) ?
				VERDICT_UDP : VERDICT_UDP_SHORT;
		else if (pkt.protocol == PROTO_ICMP)
			verdict = VERDICT_ICMP;
		else
			verdict = VERDICT_PROTO_UNREACH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (pkt.done) begin
			res.valid <= 1'b1;
		end else if (res.ready) begin
			res.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.done) begin
			res.verdict              <= verdict;
			res.protocol_number      <= pkt.protocol;
			res.source_address       <= pkt.source;
			res.udp_destination_port <= pkt.port;
			res.header_bytes         <= hdr;
			res.total_length         <= pkt.length;
		end
	end

endmodule

`default_nettype wire

@@ design/ipv4_receive_header_check.sv @@
// ----------------------------------------------------------------------------
// ipv4_receive_header_check: IPv4 receive header check, top level
// Takes a packet one byte per item and gives one verdict item per packet.
// ----------------------------------------------------------------------------
// Throughput: one byte item per cycle, sustained; only the final byte of a
//   packet waits, and only while the previous result is still held.
// Result path: the last byte is taken into the input register, then the
//   result register is loaded from it once the result slot is free.
// Reset: arst_n clears the local address to zero, drops all valid flags and
//   starts a fresh packet; no clearing pass.
`default_nettype none

module ipv4_receive_header_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ipv4rx_byte_if.sink      rx,
	ipv4rx_cfg_if.sink       cfg,
	ipv4rx_result_if.source  res
);
	import ipv4rx_pkg::*;

	logic [31:0] local_address_q;
	logic        res_free;
	pkt_t        pkt;

	// Local address register; always ready. The user must write it only
	// between packets, so each destination byte sees a stable value; the block does not enforce this.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= '0;
		end else if (cfg.valid) begin
			local_address_q <= cfg.data;
		end
	end

	// Byte parser: input register plus header state. A non-final byte never
	// waits on the result side; only the final byte needs a free result slot.
	ipv4rx_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx            (rx),
		.local_address (local_address_q),
		.res_free      (res_free),
		.pkt           (pkt)
	);

	// Verdict priority: version, length, checksum, destination, protocol.
	ipv4rx_verdict u_verdict (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt      (pkt),
		.res_free (res_free),
		.res      (res)
	);

`ifndef NO_ASSERTIONS
	// a finished packet only moves into a free result slot
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		pkt.done |-> res_free)
		else $error("packet finished while result slot occupied");

	// a finished packet always shows up as a result next cycle
	a_done_res: assert property (@(posedge clk) disable iff (!arst_n)
		pkt.done |=> res.valid)
		else $error("finished packet gave no result");

	// a udp verdict implies the length checks passed
	a_udp_len: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.verdict == VERDICT_UDP) |->
		(res.header_bytes >= 6'(MIN_HEADER_BYTES) &&
		res.total_length >= {10'd0, res.header_bytes}))
		else $error("udp verdict with inconsistent lengths");
`endif

endmodule

`default_nettype wire
